[hw/rtl/cst_pkg.sv]
// Shared types and codes for the capability set table.
// Used by cst_mem, cst_alu, capability_set_table and the testbench; depends on nothing.
package cst_pkg;

  localparam int TASKS_DEF = 64;
  localparam int SETS      = 3;
  localparam int WORD_W    = 64;
  localparam int TASK_W    = 7;
  localparam int CAP_W     = 7;

  // Operation codes.
  localparam logic [2:0] KIND_WRITE     = 3'd0;
  localparam logic [2:0] KIND_READ      = 3'd1;
  localparam logic [2:0] KIND_TEST      = 3'd2;
  localparam logic [2:0] KIND_EXEC      = 3'd3;
  localparam logic [2:0] KIND_NARROW    = 3'd4;
  localparam logic [2:0] KIND_READ_BND  = 3'd5;

  // Set select codes.
  localparam logic [1:0] SEL_EFFECTIVE   = 2'd0;
  localparam logic [1:0] SEL_PERMITTED   = 2'd1;
  localparam logic [1:0] SEL_INHERITABLE = 2'd2;
  localparam logic [1:0] SEL_INVALID     = 2'd3;

  // One table row holds all three words of one task.
  typedef struct packed {
    logic [WORD_W-1:0] eff;
    logic [WORD_W-1:0] perm;
    logic [WORD_W-1:0] inh;
  } row_t;

  localparam row_t RESET_ROW = '{eff: '0, perm: '1, inh: '0};

  typedef struct packed {
    logic [2:0]        kind;
    logic [TASK_W-1:0] task_req;
    logic [1:0]        set_select;
    logic [CAP_W-1:0]  cap_index;
    logic [WORD_W-1:0] mask_value;
    logic [WORD_W-1:0] file_permitted;
    logic [WORD_W-1:0] file_inheritable;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] read_value;
    logic              bit_held;
  } res_t;

endpackage

[hw/rtl/cst_mem.sv]
// Capability row memory: one synchronous row per task, with a registered read.
// Per-row valid bits make never-written rows read as the reset row.
// Depends on cst_pkg.
module cst_mem #(
  parameter int Rows = cst_pkg::TASKS_DEF,
  parameter int RowW = (Rows > 1) ? $clog2(Rows) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [RowW-1:0] rd_addr_i,
  input  logic            wr_en_i,
  input  logic [RowW-1:0] wr_addr_i,
  input  cst_pkg::row_t   wr_row_i,
  output cst_pkg::row_t   rd_row_o
);
  import cst_pkg::*;

  row_t            mem_q [Rows];
  logic [Rows-1:0] row_vld_q;
  row_t            rd_row_q;
  logic            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_row_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  // Substitute the reset row for a row never written.
  assign rd_row_o = rd_vld_q ? rd_row_q : RESET_ROW;

endmodule

[hw/rtl/cst_alu.sv]
// Operation logic: decodes one item against its fetched row and the bound,
// producing the write-back row, the next bound and the result. Depends on cst_pkg.
module cst_alu #(
  parameter int Tasks = cst_pkg::TASKS_DEF
) (
  input  cst_pkg::req_t                 req_i,
  input  cst_pkg::row_t                 rd_row_i,
  input  logic [cst_pkg::WORD_W-1:0]    bound_i,
  output logic                          wr_en_o,
  output cst_pkg::row_t                 wr_row_o,
  output logic [cst_pkg::WORD_W-1:0]    bound_d_o,
  output cst_pkg::res_t                 res_o
);
  import cst_pkg::*;

  logic              task_ok;
  logic              set_ok;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] exec_word;

  assign task_ok   = 32'(req_i.task_req) < 32'(Tasks);
  assign set_ok    = req_i.set_select != SEL_INVALID;
  assign exec_word = (rd_row_i.inh & req_i.file_permitted)
                   | (req_i.file_inheritable & bound_i);

  always_comb begin
    unique case (req_i.set_select)
      SEL_EFFECTIVE:   word = rd_row_i.eff;
      SEL_PERMITTED:   word = rd_row_i.perm;
      SEL_INHERITABLE: word = rd_row_i.inh;
      default:         word = '0;
    endcase
  end

  always_comb begin
    wr_en_o   = 1'b0;
    wr_row_o  = rd_row_i;
    bound_d_o = bound_i;
    res_o     = '0;
    unique case (req_i.kind)
      KIND_WRITE: begin
        if (task_ok && set_ok) begin
          wr_en_o = 1'b1;
          unique case (req_i.set_select)
            SEL_EFFECTIVE:   wr_row_o.eff  = req_i.mask_value;
            SEL_PERMITTED:   wr_row_o.perm = req_i.mask_value & bound_i;
            default:         wr_row_o.inh  = req_i.mask_value;
          endcase
        end else begin
          res_o.status = 1'b1;
        end
      end
      KIND_READ: begin
        if (task_ok && set_ok) begin
          res_o.read_value = word;
        end
      end
      KIND_TEST: begin
        if (task_ok && set_ok && !req_i.cap_index[CAP_W-1]) begin
          res_o.bit_held = word[req_i.cap_index[CAP_W-2:0]];
        end
      end
      KIND_EXEC: begin
        if (task_ok) begin
          wr_en_o       = 1'b1;
          wr_row_o.perm = exec_word;
          wr_row_o.eff  = exec_word;
        end else begin
          res_o.status = 1'b1;
        end
      end
      KIND_NARROW:   bound_d_o = bound_i & req_i.mask_value;
      KIND_READ_BND: res_o.read_value = bound_i;
      default: ;
    endcase
  end

endmodule

[hw/rtl/capability_set_table.sv]
// Capability set table: each task holds effective, permitted and inheritable
// 64-bit words in one row of a synchronous memory, and a global bounding mask
// that can only narrow. In the accept cycle the row of the addressed task is
// read into the registered memory output; once the output register is free or
// draining, the operation is decoded, the row is written back and the result is
// loaded into the output register. The next item is taken in the cycle after
// that, so the read-modify-write of one item never overlaps the next read; a
// result waiting on the output does not block acceptance, only the write-back
// of the following item. Rows never written read as the reset row through a
// valid bit per row, so no clearing pass follows reset.
module capability_set_table #(
  parameter int Tasks = cst_pkg::TASKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    kind_i,
  input  logic [cst_pkg::TASK_W-1:0]    task_req_i,
  input  logic [1:0]                    set_select_i,
  input  logic [cst_pkg::CAP_W-1:0]     cap_index_i,
  input  logic [cst_pkg::WORD_W-1:0]    mask_value_i,
  input  logic [cst_pkg::WORD_W-1:0]    file_permitted_i,
  input  logic [cst_pkg::WORD_W-1:0]    file_inheritable_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic [cst_pkg::WORD_W-1:0]    read_value_o,
  output logic                          bit_held_o
);
  import cst_pkg::*;

  // Only task indexes below 2**TASK_W can ever be addressed.
  localparam int Rows = (Tasks < (1 << TASK_W)) ? Tasks : (1 << TASK_W);
  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;

  logic              accept;
  logic              finish;
  logic              busy_q;
  req_t              req_q;
  logic [WORD_W-1:0] bound_q;
  logic [WORD_W-1:0] bound_d;
  row_t              rd_row;
  row_t              wr_row;
  logic              wr_en;
  res_t              res;
  res_t              out_q;
  logic              out_valid_q;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  // Write back and emit only when the output register is free or draining.
  assign finish     = busy_q && (!out_valid_q || out_ready_i);

  cst_mem #(
    .Rows (Rows),
    .RowW (RowW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (task_req_i[RowW-1:0]),
    .wr_en_i   (finish && wr_en),
    .wr_addr_i (req_q.task_req[RowW-1:0]),
    .wr_row_i  (wr_row),
    .rd_row_o  (rd_row)
  );

  cst_alu #(
    .Tasks (Tasks)
  ) u_alu (
    .req_i     (req_q),
    .rd_row_i  (rd_row),
    .bound_i   (bound_q),
    .wr_en_o   (wr_en),
    .wr_row_o  (wr_row),
    .bound_d_o (bound_d),
    .res_o     (res)
  );

  // Capture the item payload on accept; hold it until write-back.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= '{kind:             kind_i,
                 task_req:         task_req_i,
                 set_select:       set_select_i,
                 cap_index:        cap_index_i,
                 mask_value:       mask_value_i,
                 file_permitted:   file_permitted_i,
                 file_inheritable: file_inheritable_i};
    end
    if (finish) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      bound_q     <= '1;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        bound_q     <= bound_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign read_value_o = out_q.read_value;
  assign bit_held_o   = out_q.bit_held;

  // An accepted item occupies the engine in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted item did not enter the engine");

  // A stalled output holds the pending item in the engine.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_valid_o && !out_ready_i |=> busy_q && out_valid_o)
    else $error("pending item dropped while output stalled");

  // Completion always presents a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o && !busy_q)
    else $error("finished item did not reach the output");

  // The bound never widens.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (bound_q & ~$past(bound_q)) == '0)
    else $error("bounding mask gained a bit");

endmodule

[verif/capability_set_table_tb.sv]
// Self-checking testbench for capability_set_table: a directed table of items,
// then random operation sequences, compared against typed-in results or an in-bench predictor.
// Depends on cst_pkg for the item and result types and the operation codes.
module capability_set_table_tb;
  import cst_pkg::*;

  localparam int NTASKS = TASKS_DEF;
  localparam int TIDX_W = (NTASKS > 1) ? $clog2(NTASKS) : 1;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES = 250;
  localparam logic [WORD_W-1:0] ONES = '1;

  // Codes 6 and 7 are not defined by the package; the block must ignore them.
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  typedef struct {
    req_t op;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [2:0]        kind_i = '0;
  logic [TASK_W-1:0] task_req_i = '0;
  logic [1:0]        set_select_i = '0;
  logic [CAP_W-1:0]  cap_index_i = '0;
  logic [WORD_W-1:0] mask_value_i = '0;
  logic [WORD_W-1:0] file_permitted_i = '0;
  logic [WORD_W-1:0] file_inheritable_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              status_o;
  logic [WORD_W-1:0] read_value_o;
  logic              bit_held_o;

  // Predicted block state.
  logic [WORD_W-1:0] cap_words_q [NTASKS][SETS];
  logic [WORD_W-1:0] bound_q;

  res_t     expected_q [$];
  dir_row_t dir_rows [$];
  int       mismatches = 0;
  int       hold_reqs = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  bit       quiet = 1'b0;

  capability_set_table dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .task_req_i         (task_req_i),
    .set_select_i       (set_select_i),
    .cap_index_i        (cap_index_i),
    .mask_value_i       (mask_value_i),
    .file_permitted_i   (file_permitted_i),
    .file_inheritable_i (file_inheritable_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .read_value_o       (read_value_o),
    .bit_held_o         (bit_held_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Apply one operation to the predicted state and return its result.
  function automatic res_t apply_cap_op(req_t op);
    res_t              r;
    logic              task_ok;
    logic              set_ok;
    logic [WORD_W-1:0] nxt;
    logic [TIDX_W-1:0] ti;
    r = '0;
    task_ok = op.task_req < NTASKS;
    set_ok = op.set_select != SEL_INVALID;
    ti = op.task_req[TIDX_W-1:0];
    case (op.kind)
      KIND_WRITE: begin
        if (task_ok && set_ok) begin
          // A permitted word set by a write is clipped to the bound.
          cap_words_q[ti][op.set_select] =
            (op.set_select == SEL_PERMITTED) ? (op.mask_value & bound_q) : op.mask_value;
        end else begin
          r.status = 1'b1;
        end
      end
      KIND_READ: begin
        if (task_ok && set_ok) r.read_value = cap_words_q[ti][op.set_select];
      end
      KIND_TEST: begin
        if (task_ok && set_ok && op.cap_index < WORD_W)
          r.bit_held = cap_words_q[ti][op.set_select][op.cap_index[5:0]];
      end
      KIND_EXEC: begin
        if (task_ok) begin
          nxt = (cap_words_q[ti][SEL_INHERITABLE] & op.file_permitted) |
                (op.file_inheritable & bound_q);
          cap_words_q[ti][SEL_PERMITTED] = nxt;
          cap_words_q[ti][SEL_EFFECTIVE] = nxt;
        end else begin
          r.status = 1'b1;
        end
      end
      KIND_NARROW: bound_q = bound_q & op.mask_value;
      KIND_READ_BND: r.read_value = bound_q;
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_t op_of(logic [2:0] kind, logic [TASK_W-1:0] tsk, logic [1:0] sel,
                                 logic [CAP_W-1:0] cap, logic [WORD_W-1:0] mask,
                                 logic [WORD_W-1:0] fperm, logic [WORD_W-1:0] finh);
    req_t op;
    op.kind = kind;
    op.task_req = tsk;
    op.set_select = sel;
    op.cap_index = cap;
    op.mask_value = mask;
    op.file_permitted = fperm;
    op.file_inheritable = finh;
    return op;
  endfunction

  function automatic res_t res_of(logic status, logic [WORD_W-1:0] value, logic held);
    res_t r;
    r.status = status;
    r.read_value = value;
    r.bit_held = held;
    return r;
  endfunction

  task automatic add_row(req_t op, bit typed, res_t want);
    dir_row_t row;
    row.op = op;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Offer one item, hold it until accepted, then record its expected result.
  task automatic send_cap_op(req_t op, bit typed, res_t want);
    res_t pred;
    while (!quiet && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    kind_i             <= op.kind;
    task_req_i         <= op.task_req;
    set_select_i       <= op.set_select;
    cap_index_i        <= op.cap_index;
    mask_value_i       <= op.mask_value;
    file_permitted_i   <= op.file_permitted;
    file_inheritable_i <= op.file_inheritable;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_cap_op(op);
    expected_q.push_back(typed ? want : pred);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return '0;
    if (pick < 20) return ONES;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TASK_W-1:0] rand_task();
    int pick;
    pick = $urandom_range(0, 99);
    // Keep most traffic on a few tasks so writes and execs feed later reads.
    if (pick < 60) return TASK_W'($urandom_range(0, 7));
    if (pick < 90) return TASK_W'($urandom_range(0, NTASKS - 1));
    return TASK_W'($urandom_range(NTASKS, 127));
  endfunction

  function automatic logic [1:0] rand_sel();
    return ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 2)) : SEL_INVALID;
  endfunction

  function automatic logic [CAP_W-1:0] rand_cap();
    return ($urandom_range(0, 99) < 85) ? CAP_W'($urandom_range(0, 63))
                                        : CAP_W'($urandom_range(64, 127));
  endfunction

  // Random single item of any kind, including the spare codes.
  function automatic req_t rand_noise_op();
    int         pick;
    logic [2:0] kind;
    req_t       op;
    pick = $urandom_range(0, 99);
    if (pick < 28)      kind = KIND_WRITE;
    else if (pick < 48) kind = KIND_READ;
    else if (pick < 66) kind = KIND_TEST;
    else if (pick < 80) kind = KIND_EXEC;
    else if (pick < 84) kind = KIND_NARROW;
    else if (pick < 92) kind = KIND_READ_BND;
    else                kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE7 : KIND_SPARE6;
    op = op_of(kind, rand_task(), rand_sel(), rand_cap(), rand_word(), rand_word(),
               rand_word());
    // Clear one bit at a time so the bound does not collapse to zero early.
    if (kind == KIND_NARROW) op.mask_value = ~(64'd1 << $urandom_range(0, 63));
    return op;
  endfunction

  // Receiver: random back-pressure, always ready while quiet, and a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 19);
    end
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report("result item with no expectation waiting");
      end else begin
        want = expected_q.pop_front();
        if (status_o !== want.status)
          report($sformatf("status %b, expected %b", status_o, want.status));
        if (read_value_o !== want.read_value)
          report($sformatf("read_value %h, expected %h", read_value_o, want.read_value));
        if (bit_held_o !== want.bit_held)
          report($sformatf("bit_held %b, expected %b", bit_held_o, want.bit_held));
      end
    end
  end

  initial begin
    res_t none;
    int   sent;
    int   hold_at;
    logic [TASK_W-1:0] tsk;
    none = '0;

    for (int t = 0; t < NTASKS; t++) begin
      cap_words_q[t[TIDX_W-1:0]][SEL_EFFECTIVE]   = '0;
      cap_words_q[t[TIDX_W-1:0]][SEL_PERMITTED]   = ONES;
      cap_words_q[t[TIDX_W-1:0]][SEL_INHERITABLE] = '0;
    end
    bound_q = ONES;

    // Reset state, invalid indices and the spare codes are typed in directly.
    add_row(op_of(KIND_READ, 0, SEL_EFFECTIVE, 0, 0, 0, 0), 1, res_of(0, '0, 0));
    add_row(op_of(KIND_READ, 0, SEL_PERMITTED, 0, 0, 0, 0), 1, res_of(0, ONES, 0));
    add_row(op_of(KIND_READ, 63, SEL_INHERITABLE, 0, 0, 0, 0), 1, res_of(0, '0, 0));
    add_row(op_of(KIND_READ_BND, 0, 0, 0, 0, 0, 0), 1, res_of(0, ONES, 0));
    add_row(op_of(KIND_TEST, 5, SEL_PERMITTED, 63, 0, 0, 0), 1, res_of(0, '0, 1));
    add_row(op_of(KIND_TEST, 5, SEL_PERMITTED, 64, 0, 0, 0), 1, none);
    add_row(op_of(KIND_TEST, 63, SEL_PERMITTED, 127, 0, 0, 0), 1, none);
    add_row(op_of(KIND_WRITE, 64, SEL_EFFECTIVE, 0, ONES, 0, 0), 1, res_of(1, '0, 0));
    add_row(op_of(KIND_WRITE, 127, SEL_INVALID, 0, ONES, 0, 0), 1, res_of(1, '0, 0));
    add_row(op_of(KIND_WRITE, 0, SEL_INVALID, 0, ONES, 0, 0), 1, res_of(1, '0, 0));
    add_row(op_of(KIND_EXEC, 100, SEL_EFFECTIVE, 0, 0, ONES, ONES), 1, res_of(1, '0, 0));
    add_row(op_of(KIND_READ, 64, SEL_PERMITTED, 0, 0, 0, 0), 1, none);
    add_row(op_of(KIND_READ, 0, SEL_INVALID, 0, 0, 0, 0), 1, none);
    add_row(op_of(KIND_TEST, 0, SEL_INVALID, 0, 0, 0, 0), 1, none);
    add_row(op_of(KIND_WRITE, 1, SEL_INHERITABLE, 0, ONES, 0, 0), 1, none);
    add_row(op_of(KIND_WRITE, 1, SEL_PERMITTED, 0, 64'hA5A5_A5A5_A5A5_A5A5, 0, 0), 0, none);
    add_row(op_of(KIND_NARROW, 0, 0, 0, 64'h0000_FFFF_FFFF_0000, 0, 0), 1, none);
    add_row(op_of(KIND_READ_BND, 0, 0, 0, 0, 0, 0), 1,
            res_of(0, 64'h0000_FFFF_FFFF_0000, 0));
    // Permitted write is clipped by the narrowed bound.
    add_row(op_of(KIND_WRITE, 2, SEL_PERMITTED, 0, ONES, 0, 0), 0, none);
    add_row(op_of(KIND_READ, 2, SEL_PERMITTED, 0, 0, 0, 0), 0, none);
    // Exec ignores the set select, even the invalid one.
    add_row(op_of(KIND_EXEC, 1, SEL_INVALID, 0, 0, 64'hF0F0_F0F0_F0F0_F0F0, ONES), 0, none);
    add_row(op_of(KIND_READ, 1, SEL_EFFECTIVE, 0, 0, 0, 0), 0, none);
    add_row(op_of(KIND_READ, 1, SEL_PERMITTED, 0, 0, 0, 0), 0, none);
    add_row(op_of(KIND_TEST, 1, SEL_EFFECTIVE, 16, 0, 0, 0), 0, none);
    add_row(op_of(KIND_SPARE6, 127, SEL_INVALID, 127, ONES, ONES, ONES), 1, none);
    add_row(op_of(KIND_SPARE7, 0, SEL_PERMITTED, 0, ONES, ONES, ONES), 1, none);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_cap_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);

    // Random part: mostly write-exec-read-test sequences on one task, plus noise.
    sent = 0;
    hold_at = $urandom_range(80, 150);
    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= 300 && sent < 420);
      if (sent >= hold_at && hold_at >= 0) begin
        hold_reqs++;
        hold_at = -1;
      end
      if ($urandom_range(0, 99) < 60) begin
        tsk = ($urandom_range(0, 99) < 90) ? TASK_W'($urandom_range(0, 7)) : rand_task();
        send_cap_op(op_of(KIND_WRITE, tsk, 2'($urandom_range(0, 2)), rand_cap(),
                          rand_word(), rand_word(), rand_word()), 0, none);
        send_cap_op(op_of(KIND_EXEC, tsk, 2'($urandom_range(0, 3)), rand_cap(),
                          rand_word(), rand_word(), rand_word()), 0, none);
        send_cap_op(op_of(KIND_READ, tsk, 2'($urandom_range(0, 2)), rand_cap(),
                          rand_word(), rand_word(), rand_word()), 0, none);
        send_cap_op(op_of(KIND_TEST, tsk, 2'($urandom_range(0, 2)), rand_cap(),
                          rand_word(), rand_word(), rand_word()), 0, none);
        sent += 4;
      end else begin
        send_cap_op(rand_noise_op(), 0, none);
        sent++;
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) report("expected result items left over");

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/cst_pkg.sv
hw/rtl/cst_mem.sv
hw/rtl/cst_alu.sv
hw/rtl/capability_set_table.sv
verif/capability_set_table_tb.sv
